[src/tsc_pkg.sv]
package tsc_pkg;

  localparam int WORD_W        = 64;
  localparam int COL_IN_W      = 3;
  localparam int LEN_W         = 7;
  localparam int LZ_W          = 5;
  localparam int TZ_W          = 6;
  localparam int WIN_W         = 6;
  localparam int MAX_CODE_BITS = 77;
  localparam int HI_W          = MAX_CODE_BITS - WORD_W;

  localparam int REUSE_HDR_BITS = 2;
  localparam int NEW_HDR_BITS   = 13;
  localparam int FIRST_DELTA_W  = 14;

  localparam logic [6:0]  BIAS_C1 = 7'd63;
  localparam logic [8:0]  BIAS_C2 = 9'd255;
  localparam logic [11:0] BIAS_C3 = 12'd2047;

  localparam logic signed [WORD_W-1:0] C1_MIN = -64'sd62;
  localparam logic signed [WORD_W-1:0] C1_MAX = 64'sd63;
  localparam logic signed [WORD_W-1:0] C2_MIN = -64'sd254;
  localparam logic signed [WORD_W-1:0] C2_MAX = 64'sd255;
  localparam logic signed [WORD_W-1:0] C3_MIN = -64'sd2046;
  localparam logic signed [WORD_W-1:0] C3_MAX = 64'sd2047;

  localparam logic [1:0] PFX_C1    = 2'b01;
  localparam logic [2:0] PFX_C2    = 3'b011;
  localparam logic [3:0] PFX_C3    = 4'b0111;
  localparam logic [3:0] PFX_C4    = 4'b1111;
  localparam logic [1:0] PFX_REUSE = 2'b01;
  localparam logic [1:0] PFX_NEW   = 2'b11;

  typedef enum logic [1:0] {
    CMD_HDR_TIME  = 2'd0,
    CMD_HDR_VALUE = 2'd1,
    CMD_SMP_TIME  = 2'd2,
    CMD_SMP_VALUE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              col_ok;
    logic              pending;
    logic [WORD_W-1:0] prev_time;
    logic [WORD_W-1:0] prev_delta;
    logic [WORD_W-1:0] prev_value;
    logic              win_valid;
    logic [WIN_W-1:0]  win_leading;
    logic [WIN_W-1:0]  win_trailing;
  } hist_view_t;

  typedef struct packed {
    logic              time_we;
    logic              pending;
    logic [WORD_W-1:0] time_val;
    logic              delta_we;
    logic [WORD_W-1:0] delta_val;
    logic              value_we;
    logic [WORD_W-1:0] value;
    logic              win_we;
    logic [WIN_W-1:0]  win_leading;
    logic [WIN_W-1:0]  win_trailing;
  } hist_upd_t;

  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [HI_W-1:0]   hi;
    logic [LEN_W-1:0]  n;
  } code_t;

endpackage

[src/tsc_in_if.sv]
interface tsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [tsc_pkg::COL_IN_W-1:0]  column;
  logic [tsc_pkg::WORD_W-1:0]    word;

  modport source (output valid, output cmd, output column, output word, input ready);
  modport sink (input valid, input cmd, input column, input word, output ready);
endinterface

[src/tsc_out_if.sv]
interface tsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsc_pkg::WORD_W-1:0]  chunk_bits;
  logic [tsc_pkg::LEN_W-1:0]   chunk_length;
  logic                        last_chunk;

  modport source (output valid, output chunk_bits, output chunk_length, output last_chunk,
                  input ready);
  modport sink (input valid, input chunk_bits, input chunk_length, input last_chunk,
                output ready);
endinterface

[src/time_series_xor_compressor_top.sv]
// Time-series XOR stream packer.
// sample_in carries one word per transaction: cmd selects header timestamp,
// header value, sample timestamp or sample value; column picks the value
// history for sample values. chunk_out carries the packed stream in chunks
// of 1..64 bits, bit 0 first; last_chunk marks the final chunk of a word.
// A word that is taken sits in the input register; if it has a chunk, it
// then moves to the output register, which offers its first chunk.
// One word per cycle while codes fit in 64 bits and chunk_out is ready. A
// code longer than 64 bits (a raw-length value field plus header) leaves as
// two chunks, so that word holds the output register for both of them.
// A sample value for a column at or above NUM_COLUMNS gives no chunk.
// Reset (rst, synchronous) empties both registers, zeroes all time and
// value history, clears the zero windows and arms the first-sample delta.
// When chunk_out stalls, the output register holds its chunk; the input
// register still takes words, and sample_in.ready drops once it holds one
// with a chunk, until the output register frees up.
module time_series_xor_compressor_top #(
  parameter int NUM_COLUMNS = 8
) (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    sample_in,
  tsc_out_if.source chunk_out
);

  logic                          s1_valid;
  tsc_pkg::cmd_t                 s1_cmd;
  logic [tsc_pkg::COL_IN_W-1:0]  s1_column;
  logic [tsc_pkg::WORD_W-1:0]    s1_word;

  tsc_pkg::hist_view_t           view;
  tsc_pkg::hist_upd_t            upd;
  tsc_pkg::code_t                code;
  logic                          has_result;

  logic                          ob_valid;
  logic                          ob_phase;
  tsc_pkg::code_t                ob_code;
  logic                          ob_long;
  logic                          ob_last_shown;
  logic                          out_fire;
  logic                          ob_free;
  logic                          s1_adv;
  logic                          in_fire;

  assign ob_long       = (ob_code.n > tsc_pkg::LEN_W'(tsc_pkg::WORD_W));
  assign ob_last_shown = ob_phase || !ob_long;
  assign out_fire      = chunk_out.valid && chunk_out.ready;
  assign ob_free       = !ob_valid || (out_fire && ob_last_shown);
  // words without a chunk drop out even while the output register is busy
  assign s1_adv        = s1_valid && (!has_result || ob_free);
  assign sample_in.ready = !s1_valid || s1_adv;
  assign in_fire       = sample_in.valid && sample_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd    <= tsc_pkg::cmd_t'(sample_in.cmd);
      s1_column <= sample_in.column;
      s1_word   <= sample_in.word;
    end
  end

  tsc_history #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .commit (s1_adv),
    .column (s1_column),
    .upd    (upd),
    .view   (view)
  );

  tsc_encoder u_encoder (
    .cmd        (s1_cmd),
    .word       (s1_word),
    .view       (view),
    .has_result (has_result),
    .code       (code),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_phase <= 1'b0;
    end else if (s1_adv && has_result) begin
      ob_valid <= 1'b1;
      ob_phase <= 1'b0;
    end else if (out_fire) begin
      if (ob_last_shown) begin
        ob_valid <= 1'b0;
      end else begin
        ob_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) ob_code <= code;
  end

  assign chunk_out.valid        = ob_valid;
  assign chunk_out.chunk_bits   = ob_phase ? tsc_pkg::WORD_W'(ob_code.hi) : ob_code.lo;
  assign chunk_out.chunk_length = ob_phase ? (ob_code.n - tsc_pkg::LEN_W'(tsc_pkg::WORD_W))
                                  : (ob_long ? tsc_pkg::LEN_W'(tsc_pkg::WORD_W) : ob_code.n);
  assign chunk_out.last_chunk   = ob_last_shown;

endmodule

[src/tsc_encoder.sv]
module tsc_encoder (
  input  tsc_pkg::cmd_t                cmd,
  input  logic [tsc_pkg::WORD_W-1:0]   word,
  input  tsc_pkg::hist_view_t          view,
  output logic                         has_result,
  output tsc_pkg::code_t               code,
  output tsc_pkg::hist_upd_t           upd
);

  localparam int W = tsc_pkg::WORD_W;
  localparam int A = tsc_pkg::MAX_CODE_BITS;

  // Index of the lowest set bit; the isolated bit is one-hot, so OR its positions.
  function automatic logic [tsc_pkg::TZ_W-1:0] low_index(input logic [W-1:0] v);
    logic [W-1:0]              iso;
    logic [tsc_pkg::TZ_W-1:0]  idx;
    iso = v & (~v + W'(1));
    idx = '0;
    for (int i = 0; i < W; i++) begin
      if (iso[i]) idx = idx | tsc_pkg::TZ_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [W-1:0] reverse(input logic [W-1:0] v);
    logic [W-1:0] r;
    for (int i = 0; i < W; i++) r[i] = v[W-1-i];
    return r;
  endfunction

  logic [W-1:0]               delta1;
  logic [W-1:0]               dod;
  logic signed [W-1:0]        sdod;
  logic [W-1:0]               x;
  logic                       x_zero;
  logic [tsc_pkg::TZ_W-1:0]   tz;
  logic [tsc_pkg::TZ_W-1:0]   lz_full;
  logic [tsc_pkg::LZ_W-1:0]   lzs;
  logic [tsc_pkg::LEN_W-1:0]  len;
  logic [W-1:0]               payload;
  logic                       reuse;
  logic [A-1:0]               acc;
  logic [tsc_pkg::LEN_W-1:0]  n;
  logic [6:0]                 d7;
  logic [8:0]                 d9;
  logic [11:0]                d12;

  assign delta1 = word - view.prev_time;
  assign dod    = delta1 - view.prev_delta;
  assign sdod   = $signed(dod);
  assign d7     = dod[6:0] + tsc_pkg::BIAS_C1;
  assign d9     = dod[8:0] + tsc_pkg::BIAS_C2;
  assign d12    = dod[11:0] + tsc_pkg::BIAS_C3;

  assign x       = word ^ view.prev_value;
  assign x_zero  = (x == '0);
  assign tz      = low_index(x);
  assign lz_full = low_index(reverse(x));
  // saturate leading zeros so they fit the 5-bit field
  assign lzs     = lz_full[tsc_pkg::TZ_W-1] ? '1 : lz_full[tsc_pkg::LZ_W-1:0];
  assign len     = tsc_pkg::LEN_W'(W) - tsc_pkg::LEN_W'(lzs) - tsc_pkg::LEN_W'(tz);
  assign payload = x >> tz;
  assign reuse   = view.win_valid && (view.win_leading == tsc_pkg::WIN_W'(lzs))
                   && (view.win_trailing == tz);

  always_comb begin
    acc = '0;
    n   = tsc_pkg::LEN_W'(W);
    unique case (cmd) inside
      tsc_pkg::CMD_HDR_TIME, tsc_pkg::CMD_HDR_VALUE: begin
        acc = A'(word);
        n   = tsc_pkg::LEN_W'(W);
      end
      tsc_pkg::CMD_SMP_TIME: begin
        if (view.pending) begin
          acc = A'(delta1[tsc_pkg::FIRST_DELTA_W-1:0]);
          n   = tsc_pkg::LEN_W'(tsc_pkg::FIRST_DELTA_W);
        end else if (dod == '0) begin
          acc = '0;
          n   = tsc_pkg::LEN_W'(1);
        end else if (sdod >= tsc_pkg::C1_MIN && sdod <= tsc_pkg::C1_MAX) begin
          acc = A'({d7, tsc_pkg::PFX_C1});
          n   = tsc_pkg::LEN_W'(9);
        end else if (sdod >= tsc_pkg::C2_MIN && sdod <= tsc_pkg::C2_MAX) begin
          acc = A'({d9, tsc_pkg::PFX_C2});
          n   = tsc_pkg::LEN_W'(12);
        end else if (sdod >= tsc_pkg::C3_MIN && sdod <= tsc_pkg::C3_MAX) begin
          acc = A'({d12, tsc_pkg::PFX_C3});
          n   = tsc_pkg::LEN_W'(16);
        end else begin
          acc = A'({dod[31:0], tsc_pkg::PFX_C4});
          n   = tsc_pkg::LEN_W'(36);
        end
      end
      tsc_pkg::CMD_SMP_VALUE: begin
        if (x_zero) begin
          acc = '0;
          n   = tsc_pkg::LEN_W'(1);
        end else if (reuse) begin
          acc = (A'(payload) << tsc_pkg::REUSE_HDR_BITS) | A'(tsc_pkg::PFX_REUSE);
          n   = tsc_pkg::LEN_W'(tsc_pkg::REUSE_HDR_BITS) + len;
        end else begin
          // a length of 64 wraps to 0 in the 6-bit field
          acc = (A'(payload) << tsc_pkg::NEW_HDR_BITS)
                | A'({len[5:0], lzs, tsc_pkg::PFX_NEW});
          n   = tsc_pkg::LEN_W'(tsc_pkg::NEW_HDR_BITS) + len;
        end
      end
      default: begin
        acc = '0;
        n   = tsc_pkg::LEN_W'(W);
      end
    endcase
  end

  assign has_result = !((cmd == tsc_pkg::CMD_SMP_VALUE) && !view.col_ok);
  assign code.lo    = acc[W-1:0];
  assign code.hi    = acc[A-1:W];
  assign code.n     = n;

  assign upd.time_we      = (cmd == tsc_pkg::CMD_HDR_TIME) || (cmd == tsc_pkg::CMD_SMP_TIME);
  assign upd.pending      = (cmd == tsc_pkg::CMD_HDR_TIME);
  assign upd.time_val     = word;
  assign upd.delta_we     = (cmd == tsc_pkg::CMD_SMP_TIME);
  assign upd.delta_val    = delta1;
  assign upd.value_we     = (cmd == tsc_pkg::CMD_SMP_VALUE) && view.col_ok;
  assign upd.value        = word;
  assign upd.win_we       = upd.value_we && !x_zero && !reuse;
  assign upd.win_leading  = tsc_pkg::WIN_W'(lzs);
  assign upd.win_trailing = tz;

endmodule

[src/tsc_history.sv]
module tsc_history #(
  parameter int NUM_COLUMNS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  logic [tsc_pkg::COL_IN_W-1:0]  column,
  input  tsc_pkg::hist_upd_t            upd,
  output tsc_pkg::hist_view_t           view
);

  localparam int COL_IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int COL_EXT_W = COL_IDX_W + tsc_pkg::COL_IN_W;

  logic [COL_EXT_W-1:0]        col_ext;
  logic [COL_IDX_W-1:0]        col_idx;
  logic                        col_ok;

  logic                        pending;
  logic [tsc_pkg::WORD_W-1:0]  prev_time;
  // last timestamp delta, i.e. previous time minus the one before it
  logic [tsc_pkg::WORD_W-1:0]  prev_delta;
  logic [tsc_pkg::WORD_W-1:0]  values [NUM_COLUMNS];
  logic [tsc_pkg::WIN_W-1:0]   win_leading [NUM_COLUMNS];
  logic [tsc_pkg::WIN_W-1:0]   win_trailing [NUM_COLUMNS];
  logic [NUM_COLUMNS-1:0]      win_valid;

  assign col_ext = {{COL_IDX_W{1'b0}}, column};
  assign col_idx = col_ext[COL_IDX_W-1:0];
  assign col_ok  = (col_ext < COL_EXT_W'(NUM_COLUMNS));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b1;
      prev_time  <= '0;
      prev_delta <= '0;
      win_valid  <= '0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        values[i]       <= '0;
        win_leading[i]  <= '0;
        win_trailing[i] <= '0;
      end
    end else if (commit) begin
      if (upd.time_we) begin
        prev_time <= upd.time_val;
        pending   <= upd.pending;
      end
      if (upd.delta_we) prev_delta <= upd.delta_val;
      if (upd.value_we) values[col_idx] <= upd.value;
      if (upd.win_we) begin
        win_leading[col_idx]  <= upd.win_leading;
        win_trailing[col_idx] <= upd.win_trailing;
        win_valid[col_idx]    <= 1'b1;
      end
    end
  end

  assign view.col_ok       = col_ok;
  assign view.pending      = pending;
  assign view.prev_time    = prev_time;
  assign view.prev_delta   = prev_delta;
  assign view.prev_value   = values[col_idx];
  assign view.win_valid    = win_valid[col_idx];
  assign view.win_leading  = win_leading[col_idx];
  assign view.win_trailing = win_trailing[col_idx];

endmodule

[src/tsc_checker.sv]
module tsc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tsc_pkg::WORD_W-1:0]   chunk_bits,
  input logic [tsc_pkg::LEN_W-1:0]    chunk_length,
  input logic                         last_chunk
);

  // a stalled chunk stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("chunk withdrawn while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chunk_length != '0) && (chunk_length <= tsc_pkg::LEN_W'(tsc_pkg::WORD_W)))
    else $error("chunk length out of range");

  a_first_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_chunk |-> chunk_length == tsc_pkg::LEN_W'(tsc_pkg::WORD_W))
    else $error("non-final chunk is not full");

  // the tail of a long code follows right behind its first chunk
  a_tail_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_chunk |=> out_valid)
    else $error("tail chunk missing");

  a_high_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chunk_bits >> chunk_length) == '0)
    else $error("bits above chunk length not zero");

endmodule

bind time_series_xor_compressor_top tsc_checker u_tsc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (chunk_out.valid),
  .out_ready    (chunk_out.ready),
  .chunk_bits   (chunk_out.chunk_bits),
  .chunk_length (chunk_out.chunk_length),
  .last_chunk   (chunk_out.last_chunk)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int TB_COLUMNS = 8;
  localparam int RANDOM_WORDS = 550;
  localparam int W = tsc_pkg::WORD_W;

  typedef struct {
    tsc_pkg::cmd_t     cmd;
    logic [2:0]        column;
    logic [W-1:0]      word;
  } word_item_t;

  typedef struct {
    logic [W-1:0]                bits;
    logic [tsc_pkg::LEN_W-1:0]   len;
    logic                        last;
  } chunk_t;

  logic clk;
  logic rst;

  tsc_in_if  sample_in();
  tsc_out_if chunk_out();

  time_series_xor_compressor_top #(
    .NUM_COLUMNS(TB_COLUMNS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_in(sample_in),
    .chunk_out(chunk_out)
  );

  word_item_t word_queue[$];
  chunk_t     want_chunks[$];
  int         mismatches = 0;
  int         accepted = 0;

  // Predictor history
  logic                       hist_first;
  logic [W-1:0]               hist_time;
  logic [W-1:0]               hist_before;
  logic [W-1:0]               hist_val[TB_COLUMNS];
  logic [tsc_pkg::WIN_W-1:0]  win_lead[TB_COLUMNS];
  logic [tsc_pkg::WIN_W-1:0]  win_trail[TB_COLUMNS];
  logic                       win_ok[TB_COLUMNS];
  logic [127:0]               stream_acc;
  int unsigned                stream_n;

  // Generator copy of the timeline and column values
  logic [W-1:0] g_prev;
  logic [W-1:0] g_before;
  logic [W-1:0] g_vals[TB_COLUMNS];
  int unsigned  g_lz[TB_COLUMNS];
  int unsigned  g_tz[TB_COLUMNS];

  function automatic int unsigned count_lead(logic [W-1:0] x);
    int unsigned n;
    n = 0;
    while (n < 64 && !x[63-n]) n++;
    return n;
  endfunction

  function automatic int unsigned count_trail(logic [W-1:0] x);
    int unsigned n;
    n = 0;
    while (n < 64 && !x[n]) n++;
    return n;
  endfunction

  task automatic add_bits(logic [W-1:0] v, int unsigned k);
    logic [127:0] wide;
    if (k == 0) return;
    wide = {64'b0, v};
    if (k < 64) wide = wide & ((128'h1 << k) - 128'h1);
    stream_acc = stream_acc | (wide << stream_n);
    stream_n = stream_n + k;
  endtask

  task automatic code_stamp(logic [W-1:0] t);
    logic signed [W-1:0] d;
    if (hist_first) begin
      add_bits(t - hist_time, tsc_pkg::FIRST_DELTA_W);
      hist_first = 1'b0;
    end else begin
      d = (t - hist_time) - (hist_time - hist_before);
      if (d == 0) begin
        add_bits(64'd0, 1);
      end else if (d >= -62 && d <= 63) begin
        add_bits(64'd1, 2);
        add_bits(d + 64'sd63, 7);
      end else if (d >= -254 && d <= 255) begin
        add_bits(64'd3, 3);
        add_bits(d + 64'sd255, 9);
      end else if (d >= -2046 && d <= 2047) begin
        add_bits(64'd7, 4);
        add_bits(d + 64'sd2047, 12);
      end else begin
        add_bits(64'd15, 4);
        add_bits(d, 32);
      end
    end
    hist_before = hist_time;
    hist_time = t;
  endtask

  task automatic code_sample(int c, logic [W-1:0] w);
    logic [W-1:0] x;
    int unsigned lz;
    int unsigned tz;
    int unsigned len;
    x = w ^ hist_val[c];
    hist_val[c] = w;
    if (x == 0) begin
      add_bits(64'd0, 1);
      return;
    end
    lz = count_lead(x);
    tz = count_trail(x);
    if (lz > 31) lz = 31;
    len = 64 - lz - tz;
    if (win_ok[c] && win_lead[c] == lz && win_trail[c] == tz) begin
      add_bits(64'd1, 2);
    end else begin
      add_bits(64'd3, 2);
      add_bits(64'(lz), 5);
      add_bits(64'(len & 63), 6);
      win_lead[c] = tsc_pkg::WIN_W'(lz);
      win_trail[c] = tsc_pkg::WIN_W'(tz);
      win_ok[c] = 1'b1;
    end
    add_bits(x >> tz, len);
  endtask

  task automatic encode_word(word_item_t it);
    chunk_t ch;
    stream_acc = '0;
    stream_n = 0;
    case (it.cmd)
      tsc_pkg::CMD_HDR_TIME: begin
        add_bits(it.word, 64);
        hist_time = it.word;
        hist_first = 1'b1;
      end
      tsc_pkg::CMD_HDR_VALUE: add_bits(it.word, 64);
      tsc_pkg::CMD_SMP_TIME: code_stamp(it.word);
      default: begin
        if (int'(it.column) >= TB_COLUMNS) return;
        code_sample(int'(it.column), it.word);
      end
    endcase
    if (stream_n <= 64) begin
      ch.bits = stream_acc[63:0];
      ch.len = tsc_pkg::LEN_W'(stream_n);
      ch.last = 1'b1;
      want_chunks.insert(want_chunks.size(), ch);
    end else begin
      ch.bits = stream_acc[63:0];
      ch.len = tsc_pkg::LEN_W'(64);
      ch.last = 1'b0;
      want_chunks.insert(want_chunks.size(), ch);
      ch.bits = stream_acc[127:64];
      ch.len = tsc_pkg::LEN_W'(stream_n - 64);
      ch.last = 1'b1;
      want_chunks.insert(want_chunks.size(), ch);
    end
  endtask

  // Stimulus helpers keep the generator timeline in step with the queue
  task automatic push_item(tsc_pkg::cmd_t cmd, logic [2:0] col, logic [W-1:0] w);
    word_item_t it;
    it.cmd = cmd;
    it.column = col;
    it.word = w;
    word_queue.insert(word_queue.size(), it);
    case (cmd)
      tsc_pkg::CMD_HDR_TIME: g_prev = w;
      tsc_pkg::CMD_SMP_TIME: begin
        g_before = g_prev;
        g_prev = w;
      end
      tsc_pkg::CMD_SMP_VALUE: g_vals[col] = w;
      default: ;
    endcase
  endtask

  task automatic push_dod(logic [W-1:0] d);
    push_item(tsc_pkg::CMD_SMP_TIME, 3'($urandom), g_prev + (g_prev - g_before) + d);
  endtask

  task automatic push_xor(logic [2:0] col, logic [W-1:0] x);
    push_item(tsc_pkg::CMD_SMP_VALUE, col, g_vals[col] ^ x);
  endtask

  function automatic logic [W-1:0] make_xor(int unsigned lz, int unsigned tz);
    logic [W-1:0] r;
    r = {$urandom, $urandom};
    r = r | 64'h8000_0000_0000_0001;
    r = r >> lz;
    r = (r >> tz) << tz;
    r = r | (64'h1 << tz);
    return r;
  endfunction

  task automatic push_random_dod();
    logic [W-1:0] d;
    int pick;
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = 64'($signed($urandom_range(0, 125)) - 62);
      2: d = 64'($signed($urandom_range(0, 509)) - 254);
      3: d = 64'($signed($urandom_range(0, 4093)) - 2046);
      4: d = {$urandom, $urandom};
      default: begin
        pick = $urandom_range(0, 11);
        case (pick)
          0: d = 64'd63;
          1: d = -64'sd62;
          2: d = 64'd64;
          3: d = -64'sd63;
          4: d = 64'd255;
          5: d = -64'sd254;
          6: d = 64'd256;
          7: d = -64'sd255;
          8: d = 64'd2047;
          9: d = -64'sd2046;
          10: d = 64'd2048;
          default: d = -64'sd2047;
        endcase
      end
    endcase
    push_dod(d);
  endtask

  task automatic push_random_value();
    logic [2:0] col;
    int unsigned kind;
    col = 3'($urandom_range(0, TB_COLUMNS - 1));
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      push_xor(col, '0);
    end else if (kind < 55) begin
      push_xor(col, make_xor(g_lz[col], g_tz[col]));
    end else if (kind < 90) begin
      g_lz[col] = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 63)
                                              : $urandom_range(0, 31);
      g_tz[col] = $urandom_range(0, 63 - g_lz[col]);
      if ($urandom_range(0, 7) == 0) g_tz[col] = 0;
      push_xor(col, make_xor(g_lz[col], g_tz[col]));
    end else begin
      push_item(tsc_pkg::CMD_SMP_VALUE, col, {$urandom, $urandom});
    end
  endtask

  task automatic fill_words();
    int r;
    g_prev = '0;
    g_before = '0;
    for (int c = 0; c < TB_COLUMNS; c++) begin
      g_vals[c] = '0;
      g_lz[c] = 0;
      g_tz[c] = 0;
    end
    // Directed: raw headers, first delta, delta-of-delta class edges
    push_item(tsc_pkg::CMD_HDR_VALUE, 3'd0, 64'd0);
    push_item(tsc_pkg::CMD_HDR_VALUE, 3'd7, '1);
    push_item(tsc_pkg::CMD_HDR_TIME, 3'd5, 64'h0123_4567_89AB_CDEF);
    push_item(tsc_pkg::CMD_SMP_TIME, 3'd0, g_prev + 64'h3FFF);
    push_dod(64'd0);
    push_dod(64'd63);
    push_dod(-64'sd62);
    push_dod(64'd64);
    push_dod(-64'sd63);
    push_dod(64'd255);
    push_dod(-64'sd254);
    push_dod(64'd2047);
    push_dod(-64'sd2046);
    push_dod(64'd2048);
    push_dod(-64'sd2047);
    push_dod(64'h7FFF_FFFF_8000_1234);
    push_item(tsc_pkg::CMD_HDR_TIME, 3'd0, '1);
    push_item(tsc_pkg::CMD_SMP_TIME, 3'd0, 64'hFEDC_BA98_7654_3210);
    // Directed: zero xor, full width new window, reuse, saturated leading zeros
    push_xor(3'd0, '0);
    push_xor(3'd0, '1);
    push_xor(3'd0, 64'h8000_0000_0000_0001);
    push_xor(3'd0, 64'h1);
    push_xor(3'd0, 64'h0000_0010_0000_0001);
    push_xor(3'd7, 64'h8000_0000_0000_0000);
    push_xor(3'd7, 64'h8000_0000_0000_0000);
    // Random: mostly well-formed series with some raw noise
    while (word_queue.size() < RANDOM_WORDS + 25) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_item(tsc_pkg::CMD_HDR_TIME, 3'($urandom), {$urandom, $urandom});
      end else if (r < 7) begin
        push_item(tsc_pkg::CMD_HDR_VALUE, 3'($urandom), {$urandom, $urandom});
      end else if (r < 10) begin
        push_item(tsc_pkg::cmd_t'($urandom_range(0, 3)), 3'($urandom),
                  {$urandom, $urandom});
      end else if (r < 40) begin
        push_random_dod();
      end else begin
        push_random_value();
      end
    end
  endtask

  function automatic logic quiet_span();
    return accepted >= 250 && accepted < 370;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

  // Driver: hold a transaction until accepted, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      sample_in.valid <= 1'b0;
      hist_first = 1'b1;
      hist_time = '0;
      hist_before = '0;
      for (int c = 0; c < TB_COLUMNS; c++) begin
        hist_val[c] = '0;
        win_lead[c] = '0;
        win_trail[c] = '0;
        win_ok[c] = 1'b0;
      end
    end else if (!(sample_in.valid && !sample_in.ready)) begin
      if (sample_in.valid) begin
        encode_word(word_queue.pop_front());
        accepted++;
      end
      if (word_queue.size() != 0 && (quiet_span() || $urandom_range(0, 99) >= 16)) begin
        sample_in.valid  <= 1'b1;
        sample_in.cmd    <= word_queue[0].cmd;
        sample_in.column <= word_queue[0].column;
        sample_in.word   <= word_queue[0].word;
      end else begin
        sample_in.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each chunk against the oldest predicted one
  always @(posedge clk) begin
    chunk_t want;
    if (rst) begin
      chunk_out.ready <= 1'b0;
    end else begin
      if (chunk_out.valid && chunk_out.ready) begin
        if (want_chunks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected chunk: bits=%h len=%0d last=%b",
                     chunk_out.chunk_bits, chunk_out.chunk_length, chunk_out.last_chunk);
        end else begin
          want = want_chunks.pop_front();
          if (chunk_out.chunk_bits !== want.bits || chunk_out.chunk_length !== want.len ||
              chunk_out.last_chunk !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"chunk mismatch: want bits=%h len=%0d last=%b, ",
                        "got bits=%h len=%0d last=%b"},
                       want.bits, want.len, want.last, chunk_out.chunk_bits,
                       chunk_out.chunk_length, chunk_out.last_chunk);
          end
        end
      end
      chunk_out.ready <= quiet_span() || $urandom_range(0, 99) >= 16;
    end
  end

  initial begin
    rst = 1'b1;
    fill_words();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (word_queue.size() != 0 || sample_in.valid);
    while (want_chunks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && want_chunks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
